// ===== hdl/rop2_pkg.sv =====
// Shared codes and widths for the binary raster operation blender.
package rop2_pkg;

    localparam int PIXEL_W = 32;
    localparam int CHAN_W  = 8;
    localparam int COV_W   = 8;
    localparam int ROP_W   = 4;
    localparam int FMT_W   = 2;
    localparam int CFG_W   = 4;
    localparam int CFG_IDX_W = 1;

    // Raster op codes, in register order
    localparam logic [ROP_W-1:0] ROP_CLEAR      = 4'd0;
    localparam logic [ROP_W-1:0] ROP_COPY       = 4'd1;
    localparam logic [ROP_W-1:0] ROP_NSRC_AND_D = 4'd2;
    localparam logic [ROP_W-1:0] ROP_NSRC       = 4'd3;
    localparam logic [ROP_W-1:0] ROP_SRC_AND_ND = 4'd4;
    localparam logic [ROP_W-1:0] ROP_NDST       = 4'd5;
    localparam logic [ROP_W-1:0] ROP_XOR        = 4'd6;
    localparam logic [ROP_W-1:0] ROP_NAND       = 4'd7;
    localparam logic [ROP_W-1:0] ROP_AND        = 4'd8;
    localparam logic [ROP_W-1:0] ROP_XNOR       = 4'd9;
    localparam logic [ROP_W-1:0] ROP_NOOP       = 4'd10;
    localparam logic [ROP_W-1:0] ROP_NSRC_OR_D  = 4'd11;
    localparam logic [ROP_W-1:0] ROP_SRC_OR_ND  = 4'd12;
    localparam logic [ROP_W-1:0] ROP_OR         = 4'd13;
    localparam logic [ROP_W-1:0] ROP_SET        = 4'd14;
    localparam logic [ROP_W-1:0] ROP_NONE       = 4'd15;

    // Destination formats
    localparam logic [FMT_W-1:0] FMT_ARGB32 = 2'd0;
    localparam logic [FMT_W-1:0] FMT_RGB565 = 2'd1;
    localparam logic [FMT_W-1:0] FMT_A8     = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROP_CODE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_FORMAT = 1'd1;

    // Reset values
    localparam logic [ROP_W-1:0] ROP_RESET = ROP_COPY;
    localparam logic [FMT_W-1:0] FMT_RESET = FMT_ARGB32;

    localparam logic [PIXEL_W-1:0] OPAQUE_ALPHA = 32'hFF00_0000;
    localparam logic [COV_W-1:0]   COV_NONE     = 8'h00;

endpackage

// ===== hdl/rop2_pixel_blend.sv =====
// Top level of the binary raster operation pixel blender.
// One pixel item in, one pixel item out. Each accepted item goes into an input
// register, passes through the op/blend datapath and lands in the result
// register, where out_valid presents it. A new item can be accepted every
// clock while in_stall stays low, so a span streams at one pixel per cycle
// as long as the output side is not held. The
// result register parts the two sides, so the input keeps flowing while a
// finished pixel waits as long as the output side is not stalled with both
// stages full. rop_code (index 0, reset copy) picks one of fifteen ops; code 15
// passes the destination through. dest_format (index 1, reset ARGB32) selects
// ARGB32, RGB565 or A8; code 3 behaves as ARGB32. Coverage 0 keeps the
// destination, 255 takes the op result, anything else blends per channel.
// Write configuration only when no item is in flight.
module rop2_pixel_blend
(
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           cfg_write,
    input  logic [rop2_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rop2_pkg::CFG_W-1:0]     cfg_data,

    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [rop2_pkg::PIXEL_W-1:0]   src_pixel,
    input  logic [rop2_pkg::PIXEL_W-1:0]   dst_pixel,
    input  logic [rop2_pkg::COV_W-1:0]     coverage,
    input  logic                           span_end,

    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [rop2_pkg::PIXEL_W-1:0]   out_pixel,
    output logic                           span_end_out
);

    // configuration
    logic [rop2_pkg::ROP_W-1:0] rop_code_reg;
    logic [rop2_pkg::FMT_W-1:0] dest_format_reg;

    // input stage
    logic                         s1_valid_reg;
    logic [rop2_pkg::PIXEL_W-1:0] src_reg;
    logic [rop2_pkg::PIXEL_W-1:0] dst_reg;
    logic [rop2_pkg::COV_W-1:0]   cov_reg;
    logic                         span_end_reg;

    // result stage
    logic                         out_valid_reg;
    logic [rop2_pkg::PIXEL_W-1:0] out_pixel_reg;
    logic                         span_end_out_reg;

    logic [rop2_pkg::PIXEL_W-1:0] pixel_next;
    logic                         s2_take;
    logic                         s1_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rop_code_reg    <= rop2_pkg::ROP_RESET;
            dest_format_reg <= rop2_pkg::FMT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                rop2_pkg::CFG_ROP_CODE:    rop_code_reg    <= cfg_data;
                rop2_pkg::CFG_DEST_FORMAT: dest_format_reg <= cfg_data[rop2_pkg::FMT_W-1:0];
                default:                   ;
            endcase
        end
    end

    // result stage frees up when empty or being read this cycle
    assign s2_take  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !s2_take;
    assign s1_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_take || s2_take)
            begin
                s1_valid_reg <= s1_take;
            end
            if (s2_take)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_take)
        begin
            src_reg      <= src_pixel;
            dst_reg      <= dst_pixel;
            cov_reg      <= coverage;
            span_end_reg <= span_end;
        end
        if (s2_take && s1_valid_reg)
        begin
            out_pixel_reg    <= pixel_next;
            span_end_out_reg <= span_end_reg;
        end
    end

    rop2_blend_core u_core
    (
        .rop_code    (rop_code_reg),
        .dest_format (dest_format_reg),
        .src_pixel   (src_reg),
        .dst_pixel   (dst_reg),
        .coverage    (cov_reg),
        .out_pixel   (pixel_next)
    );

    assign out_valid    = out_valid_reg;
    assign out_pixel    = out_pixel_reg;
    assign span_end_out = span_end_out_reg;

    // an item in the input stage moves on whenever the result stage frees
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s2_take) |=> out_valid_reg)
        else $error("input stage item not advanced");

    // the input side only stalls when both stages are full and the output is held
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled without a full pipe");

    // a new result can only come from an occupied input stage
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg))
        else $error("result appeared from an empty input stage");

    // an empty input stage cannot fill without a new accept
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (!s1_valid_reg && !s1_take) |=> !s1_valid_reg)
        else $error("input stage filled without an accept");

endmodule

// ===== hdl/rop2_blend_core.sv =====
// Per-pixel datapath: destination expand, raster op, coverage blend, pack.
module rop2_blend_core
(
    input  logic [rop2_pkg::ROP_W-1:0]   rop_code,
    input  logic [rop2_pkg::FMT_W-1:0]   dest_format,
    input  logic [rop2_pkg::PIXEL_W-1:0] src_pixel,
    input  logic [rop2_pkg::PIXEL_W-1:0] dst_pixel,
    input  logic [rop2_pkg::COV_W-1:0]   coverage,
    output logic [rop2_pkg::PIXEL_W-1:0] out_pixel
);

    logic [rop2_pkg::PIXEL_W-1:0] dst_exp;
    logic [rop2_pkg::PIXEL_W-1:0] dst_masked;
    logic [rop2_pkg::PIXEL_W-1:0] rop_raw;
    logic [rop2_pkg::PIXEL_W-1:0] rop_res;
    logic [rop2_pkg::PIXEL_W-1:0] blended;
    logic [rop2_pkg::PIXEL_W-1:0] packed_px;
    logic [rop2_pkg::COV_W:0]     scale;
    logic                         keep_alpha;

    // scale is 1..256
    assign scale = {1'b0, coverage} + 9'd1;

    always_comb
    begin
        unique case (dest_format)
            rop2_pkg::FMT_RGB565:
            begin
                dst_exp    = {8'hFF,
                              dst_pixel[15:11], dst_pixel[15:13],
                              dst_pixel[10:5],  dst_pixel[10:9],
                              dst_pixel[4:0],   dst_pixel[4:2]};
                dst_masked = {16'd0, dst_pixel[15:0]};
            end
            rop2_pkg::FMT_A8:
            begin
                dst_exp    = {dst_pixel[7:0], 24'd0};
                dst_masked = {24'd0, dst_pixel[7:0]};
            end
            default:
            begin
                dst_exp    = dst_pixel;
                dst_masked = dst_pixel;
            end
        endcase
    end

    always_comb
    begin
        keep_alpha = 1'b0;
        unique case (rop_code)
            rop2_pkg::ROP_CLEAR:
            begin
                rop_raw    = '0;
                keep_alpha = 1'b1;
            end
            rop2_pkg::ROP_COPY:
            begin
                rop_raw    = src_pixel;
                keep_alpha = 1'b1;
            end
            rop2_pkg::ROP_NSRC_AND_D: rop_raw = ~src_pixel & dst_exp;
            rop2_pkg::ROP_NSRC:       rop_raw = ~src_pixel;
            rop2_pkg::ROP_SRC_AND_ND: rop_raw = src_pixel & ~dst_exp;
            rop2_pkg::ROP_NDST:       rop_raw = ~dst_exp;
            rop2_pkg::ROP_XOR:        rop_raw = src_pixel ^ dst_exp;
            rop2_pkg::ROP_NAND:       rop_raw = ~src_pixel | ~dst_exp;
            rop2_pkg::ROP_AND:        rop_raw = src_pixel & dst_exp;
            rop2_pkg::ROP_XNOR:       rop_raw = ~src_pixel ^ dst_exp;
            rop2_pkg::ROP_NOOP:
            begin
                rop_raw    = dst_exp;
                keep_alpha = 1'b1;
            end
            rop2_pkg::ROP_NSRC_OR_D:  rop_raw = ~src_pixel | dst_exp;
            rop2_pkg::ROP_SRC_OR_ND:  rop_raw = src_pixel | ~dst_exp;
            rop2_pkg::ROP_OR:         rop_raw = src_pixel | dst_exp;
            default:                  rop_raw = '1;
        endcase
        rop_res = keep_alpha ? rop_raw : (rop_raw | rop2_pkg::OPAQUE_ALPHA);
    end

    // d + floor((r - d) * scale / 256) per channel; scale 256 returns r exactly
    for (genvar ch = 0; ch < rop2_pkg::PIXEL_W / rop2_pkg::CHAN_W; ch++)
    begin : g_chan
        logic [rop2_pkg::CHAN_W-1:0]      r_c;
        logic [rop2_pkg::CHAN_W-1:0]      d_c;
        logic signed [rop2_pkg::CHAN_W:0] diff;
        logic signed [2*rop2_pkg::CHAN_W+2:0] prod;
        logic signed [2*rop2_pkg::CHAN_W+2:0] quo;

        assign r_c  = rop_res[ch*rop2_pkg::CHAN_W +: rop2_pkg::CHAN_W];
        assign d_c  = dst_exp[ch*rop2_pkg::CHAN_W +: rop2_pkg::CHAN_W];
        assign diff = $signed({1'b0, r_c}) - $signed({1'b0, d_c});
        assign prod = diff * $signed({1'b0, scale});
        assign quo  = prod >>> rop2_pkg::CHAN_W;
        assign blended[ch*rop2_pkg::CHAN_W +: rop2_pkg::CHAN_W] =
            d_c + quo[rop2_pkg::CHAN_W-1:0];
    end

    always_comb
    begin
        unique case (dest_format)
            rop2_pkg::FMT_RGB565:
                packed_px = {16'd0, blended[23:19], blended[15:10], blended[7:3]};
            rop2_pkg::FMT_A8:
                packed_px = {24'd0, blended[31:24]};
            default:
                packed_px = blended;
        endcase
    end

    assign out_pixel = (rop_code == rop2_pkg::ROP_NONE || coverage == rop2_pkg::COV_NONE)
                       ? dst_masked : packed_px;

endmodule

// ===== verif/rop2_pixel_blend_tb.sv =====
// Self-checking testbench for the raster op pixel blender, with its own scoreboard.
`timescale 1ns / 100ps

module rop2_pixel_blend_tb;

    localparam logic [rop2_pkg::COV_W-1:0] COV_FULL = 8'hFF;
    localparam int PHASES       = 38;      // random register settings
    localparam int PHASE_PIXELS = 50;      // items per random setting
    localparam int DRAIN_CYCLES = 8;       // pipeline is two deep; idle time before the summary
    localparam int CYCLE_LIMIT  = 200000;  // far above any correct run

    typedef struct packed {
        logic [rop2_pkg::PIXEL_W-1:0] pixel;
        logic                         span_end;
    } pixel_result_t;

    // Scoreboard: keeps its own copy of the two registers, works out the new
    // destination value for every accepted item and checks results in order.
    class blend_scoreboard;
        logic [rop2_pkg::ROP_W-1:0] rop_sel;
        logic [rop2_pkg::FMT_W-1:0] fmt_sel;
        pixel_result_t              owed_pixels[$];
        int                         errors;
        int                         checked;
        int                         partial_blends;

        function new();
            rop_sel = rop2_pkg::ROP_RESET;
            fmt_sel = rop2_pkg::FMT_RESET;
            errors = 0;
            checked = 0;
            partial_blends = 0;
        endfunction

        function void write_reg(logic [rop2_pkg::CFG_IDX_W-1:0] idx,
                                logic [rop2_pkg::CFG_W-1:0] val);
            if (idx == rop2_pkg::CFG_ROP_CODE)
                rop_sel = val[rop2_pkg::ROP_W-1:0];
            else
                fmt_sel = val[rop2_pkg::FMT_W-1:0];
        endfunction

        function int pending();
            return owed_pixels.size();
        endfunction

        function logic [rop2_pkg::PIXEL_W-1:0] raster_op(logic [rop2_pkg::PIXEL_W-1:0] s,
                                                         logic [rop2_pkg::PIXEL_W-1:0] d);
            logic [rop2_pkg::PIXEL_W-1:0] r;
            case (rop_sel)
                rop2_pkg::ROP_CLEAR:      return '0;
                rop2_pkg::ROP_COPY:       return s;
                rop2_pkg::ROP_NOOP:       return d;
                rop2_pkg::ROP_NSRC_AND_D: r = ~s & d;
                rop2_pkg::ROP_NSRC:       r = ~s;
                rop2_pkg::ROP_SRC_AND_ND: r = s & ~d;
                rop2_pkg::ROP_NDST:       r = ~d;
                rop2_pkg::ROP_XOR:        r = s ^ d;
                rop2_pkg::ROP_NAND:       r = ~s | ~d;
                rop2_pkg::ROP_AND:        r = s & d;
                rop2_pkg::ROP_XNOR:       r = ~s ^ d;
                rop2_pkg::ROP_NSRC_OR_D:  r = ~s | d;
                rop2_pkg::ROP_SRC_OR_ND:  r = s | ~d;
                rop2_pkg::ROP_OR:         r = s | d;
                default:                  r = '1;
            endcase
            return r | rop2_pkg::OPAQUE_ALPHA;
        endfunction

        // d + floor((r - d) * (cov + 1) / 256); arithmetic shift gives the floor
        function logic [rop2_pkg::CHAN_W-1:0] blend_channel(logic [rop2_pkg::CHAN_W-1:0] r,
                                                            logic [rop2_pkg::CHAN_W-1:0] d,
                                                            logic [rop2_pkg::COV_W-1:0] cov);
            int t;
            int sum;
            t = (int'(r) - int'(d)) * (int'(cov) + 1);
            sum = int'(d) + (t >>> 8);
            return sum[rop2_pkg::CHAN_W-1:0];
        endfunction

        function logic [rop2_pkg::PIXEL_W-1:0] blend_pixel(logic [rop2_pkg::PIXEL_W-1:0] r,
                                                           logic [rop2_pkg::PIXEL_W-1:0] d,
                                                           logic [rop2_pkg::COV_W-1:0] cov);
            logic [rop2_pkg::PIXEL_W-1:0] o;
            for (int k = 0; k < 4; k++)
                o[8*k +: 8] = blend_channel(r[8*k +: 8], d[8*k +: 8], cov);
            return o;
        endfunction

        function pixel_result_t blended_pixel(logic [rop2_pkg::PIXEL_W-1:0] s,
                                              logic [rop2_pkg::PIXEL_W-1:0] d,
                                              logic [rop2_pkg::COV_W-1:0] cov,
                                              logic se);
            pixel_result_t                res;
            logic [rop2_pkg::PIXEL_W-1:0] de;
            logic [rop2_pkg::PIXEL_W-1:0] r;
            logic [rop2_pkg::CHAN_W-1:0]  a;
            res.span_end = se;
            case (fmt_sel)
                rop2_pkg::FMT_RGB565: res.pixel = {16'h0, d[15:0]};
                rop2_pkg::FMT_A8:     res.pixel = {24'h0, d[7:0]};
                default:              res.pixel = d;
            endcase
            if (rop_sel != rop2_pkg::ROP_NONE && cov != rop2_pkg::COV_NONE) begin
                case (fmt_sel)
                    rop2_pkg::FMT_RGB565:
                    begin
                        // widen 565 by bit replication, narrow back by truncation
                        de = {8'hFF, d[15:11], d[15:13], d[10:5], d[10:9],
                              d[4:0], d[4:2]};
                        r = raster_op(s, de);
                        if (cov != COV_FULL)
                            r = blend_pixel(r, de, cov);
                        res.pixel = {16'h0, r[23:19], r[15:10], r[7:3]};
                    end
                    rop2_pkg::FMT_A8:
                    begin
                        de = {d[7:0], 24'h0};
                        r = raster_op(s, de);
                        a = r[31:24];
                        if (cov != COV_FULL)
                            a = blend_channel(a, d[7:0], cov);
                        res.pixel = {24'h0, a};
                    end
                    default:
                    begin
                        r = raster_op(s, d);
                        if (cov != COV_FULL)
                            r = blend_pixel(r, d, cov);
                        res.pixel = r;
                    end
                endcase
            end
            return res;
        endfunction

        function void note_input(logic [rop2_pkg::PIXEL_W-1:0] s,
                                 logic [rop2_pkg::PIXEL_W-1:0] d,
                                 logic [rop2_pkg::COV_W-1:0] cov, logic se);
            if (rop_sel != rop2_pkg::ROP_NONE && cov != rop2_pkg::COV_NONE
                && cov != COV_FULL)
                partial_blends++;
            owed_pixels.push_back(blended_pixel(s, d, cov, se));
        endfunction

        task report_error(string msg);
            $display("%0t ERROR %s", $time, msg);
            errors++;
        endtask

        task check_result(logic [rop2_pkg::PIXEL_W-1:0] pixel, logic se);
            pixel_result_t want;
            if (owed_pixels.size() == 0) begin
                report_error($sformatf("unexpected item out_pixel=%h", pixel));
                return;
            end
            want = owed_pixels.pop_front();
            checked++;
            if (pixel !== want.pixel)
                report_error($sformatf("out_pixel rop=%0d fmt=%0d exp %h got %h",
                                       rop_sel, fmt_sel, want.pixel, pixel));
            if (se !== want.span_end)
                report_error($sformatf("span_end_out exp %b got %b", want.span_end, se));
        endtask
    endclass

    // DUT-facing signals; every input starts at a known value
    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_write = 1'b0;
    logic [rop2_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [rop2_pkg::CFG_W-1:0]     cfg_data = '0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    logic [rop2_pkg::PIXEL_W-1:0]   src_pixel = '0;
    logic [rop2_pkg::PIXEL_W-1:0]   dst_pixel = '0;
    logic [rop2_pkg::COV_W-1:0]     coverage = '0;
    logic                           span_end = 1'b0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic [rop2_pkg::PIXEL_W-1:0]   out_pixel;
    logic                           span_end_out;

    blend_scoreboard sb;
    int              cycle_count = 0;
    int              settings_run = 0;

    rop2_pixel_blend dut (.*);

    always #5 clk = ~clk;

    // Monitor: both handshakes are judged on the values held just before the edge.
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall)
                sb.note_input(src_pixel, dst_pixel, coverage, span_end);
            if (out_valid && !out_stall)
                sb.check_result(out_pixel, span_end_out);
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver back-pressure: a mode is held for a random stretch, then replaced.
    // Modes: never stall, coin flip, a regular repeating stall pattern, mostly stalled.
    int stall_mode = 0;
    int stall_left = 0;
    int stall_tick = 0;
    always @(negedge clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 120);
        end
        else
            stall_left--;
        stall_tick++;
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 1) == 1);
            2:       out_stall <= (stall_tick % 3 != 0);
            default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // Both registers are written back to back; the write strobe drops once.
    // Called only with nothing in flight.
    task automatic write_setting(logic [rop2_pkg::ROP_W-1:0] rop,
                                 logic [rop2_pkg::FMT_W-1:0] fmt);
        cfg_write <= 1'b1;
        cfg_index <= rop2_pkg::CFG_ROP_CODE;
        cfg_data  <= rop2_pkg::CFG_W'(rop);
        @(posedge clk);
        sb.write_reg(rop2_pkg::CFG_ROP_CODE, rop2_pkg::CFG_W'(rop));
        @(negedge clk);
        cfg_index <= rop2_pkg::CFG_DEST_FORMAT;
        cfg_data  <= rop2_pkg::CFG_W'(fmt);
        @(posedge clk);
        sb.write_reg(rop2_pkg::CFG_DEST_FORMAT, rop2_pkg::CFG_W'(fmt));
        @(negedge clk);
        cfg_write <= 1'b0;
        settings_run++;
    endtask

    // Present one item at the falling edge and hold it until accepted.
    // Leaves in_valid high so a burst can follow without a bubble.
    task automatic send_pixel(logic [rop2_pkg::PIXEL_W-1:0] s,
                              logic [rop2_pkg::PIXEL_W-1:0] d,
                              logic [rop2_pkg::COV_W-1:0] cov, logic se);
        in_valid  <= 1'b1;
        src_pixel <= s;
        dst_pixel <= d;
        coverage  <= cov;
        span_end  <= se;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic hold_off(int n);
        if (n > 0) begin
            in_valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    // One register setting, one item, then a full drain
    task automatic directed_pixel(logic [rop2_pkg::ROP_W-1:0] rop,
                                  logic [rop2_pkg::FMT_W-1:0] fmt,
                                  logic [rop2_pkg::PIXEL_W-1:0] s,
                                  logic [rop2_pkg::PIXEL_W-1:0] d,
                                  logic [rop2_pkg::COV_W-1:0] cov, logic se);
        write_setting(rop, fmt);
        send_pixel(s, d, cov, se);
        hold_off(1);
        wait_drained();
    endtask

    // Pixels lean toward all-zero and all-one words; coverage toward 0 and 255
    // and the values next to them, so both shortcut paths and the blend get hit.
    function automatic logic [rop2_pkg::PIXEL_W-1:0] rand_pixel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [rop2_pkg::COV_W-1:0] rand_coverage();
        case ($urandom_range(0, 9))
            0, 1:    return rop2_pkg::COV_NONE;
            2, 3:    return COV_FULL;
            4:       return 8'd1;
            5:       return 8'hFE;
            default: return rop2_pkg::COV_W'($urandom_range(0, 255));
        endcase
    endfunction

    initial begin
        logic [rop2_pkg::ROP_W-1:0] rop;
        logic [rop2_pkg::FMT_W-1:0] fmt;
        int                         left;
        int                         burst;

        sb = new();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: reset setting (copy into ARGB32), coverage corners.
        send_pixel(32'hFFFF_FFFF, 32'h0000_0000, COV_FULL, 1'b1);
        send_pixel(32'h0000_0000, 32'hFFFF_FFFF, rop2_pkg::COV_NONE, 1'b0);
        send_pixel(32'h1234_5678, 32'h8765_4321, 8'd1, 1'b0);
        send_pixel(32'h0000_00FF, 32'hFFFF_FF00, 8'hFE, 1'b1);
        send_pixel(32'h80FF_00C0, 32'h7F00_FF3F, 8'd128, 1'b0);
        hold_off(1);
        wait_drained();

        // Directed: every op code including the pass-through code,
        // full coverage on even codes and a partial blend on odd ones.
        for (int op = 0; op < 16; op++)
            directed_pixel(rop2_pkg::ROP_W'(op), rop2_pkg::FMT_ARGB32,
                           32'hF0F0_5A3C, 32'h0FCC_A5C3,
                           (op % 2 == 0) ? COV_FULL : 8'd100, op[0]);

        // Directed: 565 and A8 with junk in the unused upper destination bits,
        // and the unused format code that must act as ARGB32.
        directed_pixel(rop2_pkg::ROP_XOR, rop2_pkg::FMT_RGB565,
                       32'hFF80_40C0, 32'hFFFF_F81F, 8'd77, 1'b1);
        directed_pixel(rop2_pkg::ROP_NAND, rop2_pkg::FMT_A8,
                       32'h3C00_0000, 32'hFFFF_FF80, 8'd200, 1'b0);
        directed_pixel(rop2_pkg::ROP_OR, rop2_pkg::FMT_W'(3),
                       32'h0102_0304, 32'hF0E0_D0C0, COV_FULL, 1'b1);

        // Random phases. The first 32 visit every op code twice, each time
        // under a different format code; the rest pick both at random.
        for (int p = 0; p < PHASES; p++) begin
            if (p < 32) begin
                rop = rop2_pkg::ROP_W'(p % 16);
                fmt = rop2_pkg::FMT_W'((p / 16 + p) % 4);
            end
            else begin
                rop = rop2_pkg::ROP_W'($urandom_range(0, 15));
                fmt = rop2_pkg::FMT_W'($urandom_range(0, 3));
            end
            write_setting(rop, fmt);

            left = PHASE_PIXELS;
            while (left > 0) begin
                burst = $urandom_range(1, 24);
                while (burst > 0 && left > 0) begin
                    send_pixel(rand_pixel(), rand_pixel(), rand_coverage(),
                               $urandom_range(0, 7) == 0);
                    burst--;
                    left--;
                    // now and then stop feeding until the pipe is empty
                    if (p % 7 == 3 && left == PHASE_PIXELS / 2) begin
                        hold_off(1);
                        wait_drained();
                    end
                end
                // about a third of the bursts run straight into the next one
                if ($urandom_range(0, 2) != 0)
                    hold_off($urandom_range(1, 5));
            end
            hold_off(1);
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Checked %0d pixels over %0d register settings (all ops, all format codes),",
                 sb.checked, settings_run);
        $display("%0d of them partially covered blends, with random gaps and stalls.",
                 sb.partial_blends);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
